// ----- hdl/seot_pkg.sv -----
// ----------------------------------------------------------------------------
// seot_pkg: shared types, constants and tables
// Fixed-point formats, CORDIC arctangent table and register codes for the
// equation-of-time and solar-declination pipeline.
// ----------------------------------------------------------------------------
package seot_pkg;

    // default sizing of the angle path
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // vectors are signed Q6.30 with headroom for CORDIC growth
    localparam int VEC_W = 36;
    // signed residual angle inside a rotating CORDIC
    localparam int ZR_W  = 34;

    typedef logic signed [VEC_W-1:0] t_vec;
    typedef logic [31:0]             t_turn;

    // register codes (byte address bits [3:2])
    localparam logic [1:0] REG_ECC = 2'd0;
    localparam logic [1:0] REG_LON = 2'd1;
    localparam logic [1:0] REG_OBL = 2'd2;

    // register reset values
    localparam logic [15:0] ECC_RST = 16'd1095;
    localparam logic [15:0] LON_RST = 16'd14050;
    localparam logic [15:0] OBL_RST = 16'd4267;

    // arithmetic constants
    localparam logic signed [31:0] GAIN_Q30       = 32'sd652032874;
    localparam logic signed [31:0] INV_TWO_PI_Q32 = 32'sd683565276;
    localparam logic signed [31:0] EOT_SCALE      = 32'sd91908;
    localparam logic signed [31:0] DEC_SCALE      = 32'sd92160;
    localparam logic signed [31:0] DEC_LIMIT      = 32'sd23040;
    localparam t_vec               ONE_Q30        = 36'sh0_4000_0000;
    localparam t_turn              QUARTER_TURN   = 32'h4000_0000;
    localparam t_turn              HALF_TURN      = 32'h8000_0000;

    // atan(2^-i) in 2^-32 turns
    function automatic t_turn atan_turn(input int i);
        t_turn v;
        unique case (i)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            24:      v = 32'h00000029;
            25:      v = 32'h00000014;
            26:      v = 32'h0000000A;
            27:      v = 32'h00000005;
            28:      v = 32'h00000003;
            29:      v = 32'h00000001;
            30:      v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // keep the top bits of an angle
    function automatic t_turn angle_mask(input int bits);
        t_turn m;
        if (bits >= 32) begin
            m = '1;
        end else begin
            m = t_turn'({32{1'b1}} << (32 - bits));
        end
        return m;
    endfunction

endpackage

// ----- hdl/seot_sqrt.sv -----
// ----------------------------------------------------------------------------
// seot_sqrt: pipelined integer square root
// One result bit per stage, restoring digit-by-digit method, with a
// sideband word carried alongside each beat.
// ----------------------------------------------------------------------------
module seot_sqrt #(
    parameter int IN_W   = 34,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [IN_W-1:0]   i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [IN_W/2-1:0] o_root,
    output logic [SIDE_W-1:0] o_side
);

    localparam int K = IN_W / 2;

    logic              r_vld  [0:K-1];
    logic [IN_W-1:0]   r_rem  [0:K-1];
    logic [IN_W-1:0]   r_root [0:K-1];
    logic [SIDE_W-1:0] r_side [0:K-1];

    for (genvar k = 0; k < K; k++) begin : g_stage
        localparam logic [IN_W-1:0] STEP_BIT =
            {{(IN_W-1){1'b0}}, 1'b1} << (IN_W - 2 - 2*k);
        logic              p_vld;
        logic [IN_W-1:0]   p_rem;
        logic [IN_W-1:0]   p_root;
        logic [SIDE_W-1:0] p_side;
        logic [IN_W-1:0]   n_trial;

        if (k == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_rem  = i_rad;
            assign p_root = '0;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_side = r_side[k-1];
        end

        assign n_trial = p_root + STEP_BIT;

        // advance the valid bit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= p_vld;
            end
        end

        // try one root bit
        always_ff @(posedge i_clk) begin
            if (p_rem >= n_trial) begin
                r_rem[k]  <= p_rem - n_trial;
                r_root[k] <= (p_root >> 1) + STEP_BIT;
            end else begin
                r_rem[k]  <= p_rem;
                r_root[k] <= p_root >> 1;
            end
            r_side[k] <= p_side;
        end
    end

    assign o_vld  = r_vld[K-1];
    assign o_root = r_root[K-1][K-1:0];
    assign o_side = r_side[K-1];

endmodule

// ----- hdl/seot_rot.sv -----
// ----------------------------------------------------------------------------
// seot_rot: pipelined rotating CORDIC
// Gain stage, quadrant stage, then one micro-rotation per stage; turns
// (x, y) counter-clockwise by the given angle in turns.
// ----------------------------------------------------------------------------
module seot_rot #(
    parameter int ANGLE_BITS = seot_pkg::ANGLE_BITS_DEF,
    parameter int STEPS      = seot_pkg::CORDIC_STEPS_DEF,
    parameter int SIDE_W     = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  seot_pkg::t_vec     i_x,
    input  seot_pkg::t_vec     i_y,
    input  seot_pkg::t_turn    i_ang,
    input  logic [SIDE_W-1:0]  i_side,
    output logic               o_vld,
    output seot_pkg::t_vec     o_x,
    output seot_pkg::t_vec     o_y,
    output logic [SIDE_W-1:0]  o_side
);

    localparam int              VW       = seot_pkg::VEC_W;
    localparam int              ZW       = seot_pkg::ZR_W;
    localparam seot_pkg::t_turn ANG_MASK = seot_pkg::angle_mask(ANGLE_BITS);

    // gain stage
    logic signed [VW+31:0] n_gx, n_gy;
    logic                  r_g_vld;
    seot_pkg::t_vec        r_gx, r_gy;
    seot_pkg::t_turn       r_ga;
    logic [SIDE_W-1:0]     r_g_side;

    assign n_gx = i_x * seot_pkg::GAIN_Q30;
    assign n_gy = i_y * seot_pkg::GAIN_Q30;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else begin
            r_g_vld <= i_vld;
        end
    end

    // scale by the CORDIC gain and mask the angle
    always_ff @(posedge i_clk) begin
        r_gx     <= n_gx[VW+29:30];
        r_gy     <= n_gy[VW+29:30];
        r_ga     <= i_ang & ANG_MASK;
        r_g_side <= i_side;
    end

    // quadrant stage: fold the angle into the right half-plane
    logic                  n_flip;
    seot_pkg::t_turn       n_qa;
    logic                  r_q_vld;
    seot_pkg::t_vec        r_qx, r_qy;
    logic signed [ZW-1:0]  r_qz;
    logic [SIDE_W-1:0]     r_q_side;

    assign n_flip = ((r_ga + seot_pkg::QUARTER_TURN) & seot_pkg::HALF_TURN) != '0;
    assign n_qa   = n_flip ? (r_ga + seot_pkg::HALF_TURN) : r_ga;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= 1'b0;
        end else begin
            r_q_vld <= r_g_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_qx     <= n_flip ? -r_gx : r_gx;
        r_qy     <= n_flip ? -r_gy : r_gy;
        r_qz     <= ZW'($signed(n_qa));
        r_q_side <= r_g_side;
    end

    // micro-rotation stages
    logic                 r_vld  [0:STEPS-1];
    seot_pkg::t_vec       r_x    [0:STEPS-1];
    seot_pkg::t_vec       r_y    [0:STEPS-1];
    logic signed [ZW-1:0] r_z    [0:STEPS-1];
    logic [SIDE_W-1:0]    r_side [0:STEPS-1];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam logic signed [ZW-1:0] ATAN =
            $signed({{(ZW-32){1'b0}}, seot_pkg::atan_turn(k)});
        logic                 p_vld;
        seot_pkg::t_vec       p_x, p_y;
        logic signed [ZW-1:0] p_z;
        logic [SIDE_W-1:0]    p_side;

        if (k == 0) begin : g_first
            assign p_vld  = r_q_vld;
            assign p_x    = r_qx;
            assign p_y    = r_qy;
            assign p_z    = r_qz;
            assign p_side = r_q_side;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_x    = r_x[k-1];
            assign p_y    = r_y[k-1];
            assign p_z    = r_z[k-1];
            assign p_side = r_side[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= p_vld;
            end
        end

        // rotate towards zero residual angle
        always_ff @(posedge i_clk) begin
            if (!p_z[ZW-1]) begin
                r_x[k] <= p_x - (p_y >>> k);
                r_y[k] <= p_y + (p_x >>> k);
                r_z[k] <= p_z - ATAN;
            end else begin
                r_x[k] <= p_x + (p_y >>> k);
                r_y[k] <= p_y - (p_x >>> k);
                r_z[k] <= p_z + ATAN;
            end
            r_side[k] <= p_side;
        end
    end

    assign o_vld  = r_vld[STEPS-1];
    assign o_x    = r_x[STEPS-1];
    assign o_y    = r_y[STEPS-1];
    assign o_side = r_side[STEPS-1];

endmodule

// ----- hdl/seot_vec.sv -----
// ----------------------------------------------------------------------------
// seot_vec: pipelined vectoring CORDIC
// Half-plane fold, then one micro-rotation per stage; returns atan2(y, x)
// in turns, zero for the zero vector.
// ----------------------------------------------------------------------------
module seot_vec #(
    parameter int ANGLE_BITS = seot_pkg::ANGLE_BITS_DEF,
    parameter int STEPS      = seot_pkg::CORDIC_STEPS_DEF,
    parameter int SIDE_W     = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  seot_pkg::t_vec     i_x,
    input  seot_pkg::t_vec     i_y,
    input  logic [SIDE_W-1:0]  i_side,
    output logic               o_vld,
    output seot_pkg::t_turn    o_ang,
    output logic [SIDE_W-1:0]  o_side
);

    localparam seot_pkg::t_turn ANG_MASK = seot_pkg::angle_mask(ANGLE_BITS);

    // fold stage
    logic              r_f_vld;
    logic              r_f_zero;
    seot_pkg::t_vec    r_fx, r_fy;
    seot_pkg::t_turn   r_fz;
    logic [SIDE_W-1:0] r_f_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= i_vld;
        end
    end

    // mirror a left half-plane vector and start at half a turn
    always_ff @(posedge i_clk) begin
        r_f_zero <= (i_x == '0) && (i_y == '0);
        if (i_x < 0) begin
            r_fx <= -i_x;
            r_fy <= -i_y;
            r_fz <= seot_pkg::HALF_TURN;
        end else begin
            r_fx <= i_x;
            r_fy <= i_y;
            r_fz <= '0;
        end
        r_f_side <= i_side;
    end

    // micro-rotation stages
    logic              r_vld  [0:STEPS-1];
    logic              r_zero [0:STEPS-1];
    seot_pkg::t_vec    r_x    [0:STEPS-1];
    seot_pkg::t_vec    r_y    [0:STEPS-1];
    seot_pkg::t_turn   r_z    [0:STEPS-1];
    logic [SIDE_W-1:0] r_side [0:STEPS-1];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam seot_pkg::t_turn ATAN = seot_pkg::atan_turn(k);
        logic              p_vld, p_zero;
        seot_pkg::t_vec    p_x, p_y;
        seot_pkg::t_turn   p_z;
        logic [SIDE_W-1:0] p_side;

        if (k == 0) begin : g_first
            assign p_vld  = r_f_vld;
            assign p_zero = r_f_zero;
            assign p_x    = r_fx;
            assign p_y    = r_fy;
            assign p_z    = r_fz;
            assign p_side = r_f_side;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_zero = r_zero[k-1];
            assign p_x    = r_x[k-1];
            assign p_y    = r_y[k-1];
            assign p_z    = r_z[k-1];
            assign p_side = r_side[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= p_vld;
            end
        end

        // drive y towards zero, accumulate the angle
        always_ff @(posedge i_clk) begin
            if (p_y < 0) begin
                r_x[k] <= p_x - (p_y >>> k);
                r_y[k] <= p_y + (p_x >>> k);
                r_z[k] <= p_z - ATAN;
            end else begin
                r_x[k] <= p_x + (p_y >>> k);
                r_y[k] <= p_y - (p_x >>> k);
                r_z[k] <= p_z + ATAN;
            end
            r_zero[k] <= p_zero;
            r_side[k] <= p_side;
        end
    end

    assign o_vld  = r_vld[STEPS-1];
    assign o_ang  = r_zero[STEPS-1] ? '0 : (r_z[STEPS-1] & ANG_MASK);
    assign o_side = r_side[STEPS-1];

endmodule

// ----- hdl/solar_eot_declination_top.sv -----
// Throughput: one beat per cycle; busy stays low, every CORDIC step, root
// bit and multiply has its own register stage.
// Reset (synchronous, active low) empties the pipeline and loads the
// register defaults; results arrive on o_done for one cycle, no back-pressure.
// ----------------------------------------------------------------------------
// solar_eot_declination_top: equation of time and solar declination
// Kepler mapping, frame rotations and atan2/asin via pipelined CORDIC, with
// an APB register port for eccentricity, perihelion longitude and obliquity.
// ----------------------------------------------------------------------------
module solar_eot_declination_top #(
    parameter int ANGLE_BITS   = seot_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = seot_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [16:0]        i_year_fraction,
    output logic               o_done,
    output logic [16:0]        o_mean_date,
    output logic signed [16:0] o_time_offset,
    output logic signed [15:0] o_declination,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int VW = seot_pkg::VEC_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [15:0] r_ecc, r_lon, r_obl;
    logic        n_wr;

    assign pready = 1'b1;
    assign n_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ecc <= seot_pkg::ECC_RST;
            r_lon <= seot_pkg::LON_RST;
            r_obl <= seot_pkg::OBL_RST;
        end else if (n_wr) begin
            unique case (paddr[3:2])
                seot_pkg::REG_ECC: r_ecc <= pwdata[15:0];
                seot_pkg::REG_LON: r_lon <= pwdata[15:0];
                seot_pkg::REG_OBL: r_obl <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            seot_pkg::REG_ECC: prdata = {16'h0, r_ecc};
            seot_pkg::REG_LON: prdata = {16'h0, r_lon};
            seot_pkg::REG_OBL: prdata = {16'h0, r_obl};
            default:           prdata = '0;
        endcase
    end

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // input stage: clamp the phase, form 1 - e^2
    // ------------------------------------------------------------------
    logic        r0_vld;
    logic [16:0] r0_yf;
    logic [33:0] r0_rad;
    logic [31:0] n0_ee;

    assign n0_ee = r_ecc * r_ecc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else begin
            r0_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_yf  <= (i_year_fraction > 17'd65536) ? 17'd65536 : i_year_fraction;
        r0_rad <= 34'h1_0000_0000 - {2'b00, n0_ee};
    end

    // sqrt(1 - e^2) in Q0.16
    logic        u1_vld;
    logic [16:0] u1_b;
    logic [16:0] u1_yf;

    seot_sqrt #(.IN_W(34), .SIDE_W(17)) u_sqrt_ecc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r0_vld),
        .i_rad   (r0_rad),
        .i_side  (r0_yf),
        .o_vld   (u1_vld),
        .o_root  (u1_b),
        .o_side  (u1_yf)
    );

    // ------------------------------------------------------------------
    // cos/sin of the eccentric anomaly and of the obliquity, side by side
    // ------------------------------------------------------------------
    logic           u2a_vld, u2b_vld;
    seot_pkg::t_vec u2a_x, u2a_y, u2b_x, u2b_y;
    logic [16:0]    u2a_yf, u2b_b;

    seot_rot #(.ANGLE_BITS(ANGLE_BITS), .STEPS(CORDIC_STEPS), .SIDE_W(17)) u_rot_tau (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (u1_vld),
        .i_x     (seot_pkg::ONE_Q30),
        .i_y     ('0),
        .i_ang   ({u1_yf[15:0], 16'h0}),
        .i_side  (u1_yf),
        .o_vld   (u2a_vld),
        .o_x     (u2a_x),
        .o_y     (u2a_y),
        .o_side  (u2a_yf)
    );

    seot_rot #(.ANGLE_BITS(ANGLE_BITS), .STEPS(CORDIC_STEPS), .SIDE_W(17)) u_rot_obl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (u1_vld),
        .i_x     (seot_pkg::ONE_Q30),
        .i_y     ('0),
        .i_ang   ({r_obl, 16'h0}),
        .i_side  (u1_b),
        .o_vld   (u2b_vld),
        .o_x     (u2b_x),
        .o_y     (u2b_y),
        .o_side  (u2b_b)
    );

    // ------------------------------------------------------------------
    // orbit vector and e*sin(tau) scaled to turns
    // ------------------------------------------------------------------
    logic signed [VW+17:0] n1_pb;
    logic signed [VW+16:0] n1_pe;
    logic                  r1_vld;
    seot_pkg::t_vec        r1_vx, r1_vy, r1_d1, r1_co, r1_so;
    logic [16:0]           r1_yf;

    assign n1_pb = u2a_y * $signed({1'b0, u2b_b});
    assign n1_pe = $signed({1'b0, r_ecc}) * u2a_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= u2a_vld && u2b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_vy <= n1_pb[VW+15:16];
        r1_vx <= u2a_x - $signed(VW'({r_ecc, 14'h0}));
        r1_d1 <= n1_pe[VW+13:14];
        r1_co <= u2b_x;
        r1_so <= u2b_y;
        r1_yf <= u2a_yf;
    end

    // mean anomaly t = tau - e sin(tau) / (2 pi)
    logic signed [VW+31:0] n2_pd;
    logic                  r2_vld;
    seot_pkg::t_vec        r2_vx, r2_vy, r2_tf, r2_co, r2_so;

    assign n2_pd = r1_d1 * seot_pkg::INV_TWO_PI_Q32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_tf <= $signed({3'b000, r1_yf, 16'h0}) - n2_pd[VW+31:32];
        r2_vx <= r1_vx;
        r2_vy <= r1_vy;
        r2_co <= r1_co;
        r2_so <= r1_so;
    end

    // true longitude
    logic            u3_vld;
    seot_pkg::t_turn u3_theta;
    logic [3*VW-1:0] u3_side;

    seot_vec #(.ANGLE_BITS(ANGLE_BITS), .STEPS(CORDIC_STEPS), .SIDE_W(3*VW)) u_vec_theta (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r2_vld),
        .i_x     (r2_vx),
        .i_y     (r2_vy),
        .i_side  ({r2_tf, r2_co, r2_so}),
        .o_vld   (u3_vld),
        .o_ang   (u3_theta),
        .o_side  (u3_side)
    );

    // angle from the perihelion frame
    logic            r3_vld;
    seot_pkg::t_turn r3_ang;
    logic [3*VW-1:0] r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= u3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_ang  <= u3_theta - {r_lon, 16'h0} + seot_pkg::QUARTER_TURN;
        r3_side <= u3_side;
    end

    // unit vector along the ecliptic
    logic            u4_vld;
    seot_pkg::t_vec  u4_x, u4_y, u4_tf, u4_co, u4_so;
    logic [3*VW-1:0] u4_side;

    seot_rot #(.ANGLE_BITS(ANGLE_BITS), .STEPS(CORDIC_STEPS), .SIDE_W(3*VW)) u_rot_ecl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r3_vld),
        .i_x     (seot_pkg::ONE_Q30),
        .i_y     ('0),
        .i_ang   (r3_ang),
        .i_side  (r3_side),
        .o_vld   (u4_vld),
        .o_x     (u4_x),
        .o_y     (u4_y),
        .o_side  (u4_side)
    );

    assign {u4_tf, u4_co, u4_so} = u4_side;

    // ------------------------------------------------------------------
    // tilt into the equatorial frame, mean date and mean-time angle
    // ------------------------------------------------------------------
    logic signed [2*VW-1:0] n4_px, n4_pz;
    logic signed [VW-17:0]  n4_md;
    logic                   r4_vld;
    seot_pkg::t_vec         r4_x2, r4_y2, r4_z2;
    seot_pkg::t_turn        r4_ang;
    logic [16:0]            r4_md;

    assign n4_px = u4_co * u4_x;
    assign n4_pz = u4_so * u4_x;
    assign n4_md = u4_tf[VW-1:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= u4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_x2  <= n4_px[VW+29:30];
        r4_y2  <= u4_y;
        r4_z2  <= -$signed(n4_pz[VW+29:30]);
        r4_ang <= 32'h0 - (u4_tf[31:0] - {r_lon, 16'h0} + seot_pkg::QUARTER_TURN);
        if (n4_md < 0) begin
            r4_md <= 17'd0;
        end else if (n4_md > $signed((VW-16)'(65536))) begin
            r4_md <= 17'd65536;
        end else begin
            r4_md <= n4_md[16:0];
        end
    end

    // clamp z, form 1 - z^2
    seot_pkg::t_vec         n5_zc;
    logic signed [2*VW-1:0] n5_zz;
    logic                   r5_vld;
    seot_pkg::t_vec         r5_x2, r5_y2, r5_zc;
    seot_pkg::t_turn        r5_ang;
    logic [16:0]            r5_md;
    logic [61:0]            r5_rad;

    always_comb begin
        if (r4_z2 > seot_pkg::ONE_Q30) begin
            n5_zc = seot_pkg::ONE_Q30;
        end else if (r4_z2 < -seot_pkg::ONE_Q30) begin
            n5_zc = -seot_pkg::ONE_Q30;
        end else begin
            n5_zc = r4_z2;
        end
    end

    assign n5_zz = n5_zc * n5_zc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_rad <= 62'h1000_0000_0000_0000 - n5_zz[61:0];
        r5_x2  <= r4_x2;
        r5_y2  <= r4_y2;
        r5_zc  <= n5_zc;
        r5_ang <= r4_ang;
        r5_md  <= r4_md;
    end

    // cosine of the declination
    localparam int S6_W = 3*VW + 32 + 17;

    logic            u6_vld;
    logic [30:0]     u6_w;
    seot_pkg::t_vec  u6_x2, u6_y2, u6_zc;
    seot_pkg::t_turn u6_ang;
    logic [16:0]     u6_md;
    logic [S6_W-1:0] u6_side;

    seot_sqrt #(.IN_W(62), .SIDE_W(S6_W)) u_sqrt_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r5_vld),
        .i_rad   (r5_rad),
        .i_side  ({r5_x2, r5_y2, r5_zc, r5_ang, r5_md}),
        .o_vld   (u6_vld),
        .o_root  (u6_w),
        .o_side  (u6_side)
    );

    assign {u6_x2, u6_y2, u6_zc, u6_ang, u6_md} = u6_side;

    // rotate clockwise by the mean-time angle
    localparam int S7_W = 31 + VW + 17;

    logic            u7_vld;
    seot_pkg::t_vec  u7_x, u7_y, u7_zc;
    logic [30:0]     u7_w;
    logic [16:0]     u7_md;
    logic [S7_W-1:0] u7_side;

    seot_rot #(.ANGLE_BITS(ANGLE_BITS), .STEPS(CORDIC_STEPS), .SIDE_W(S7_W)) u_rot_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (u6_vld),
        .i_x     (u6_x2),
        .i_y     (u6_y2),
        .i_ang   (u6_ang),
        .i_side  ({u6_w, u6_zc, u6_md}),
        .o_vld   (u7_vld),
        .o_x     (u7_x),
        .o_y     (u7_y),
        .o_side  (u7_side)
    );

    assign {u7_w, u7_zc, u7_md} = u7_side;

    // ------------------------------------------------------------------
    // both final angles side by side; the mean date rides in two halves
    // ------------------------------------------------------------------
    logic            u8a_vld, u8b_vld;
    seot_pkg::t_turn u8a_ang, u8b_ang;
    logic [8:0]      u8a_md_hi;
    logic [7:0]      u8b_md_lo;

    seot_vec #(.ANGLE_BITS(ANGLE_BITS), .STEPS(CORDIC_STEPS), .SIDE_W(9)) u_vec_eot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (u7_vld),
        .i_x     (u7_x),
        .i_y     (u7_y),
        .i_side  (u7_md[16:8]),
        .o_vld   (u8a_vld),
        .o_ang   (u8a_ang),
        .o_side  (u8a_md_hi)
    );

    seot_vec #(.ANGLE_BITS(ANGLE_BITS), .STEPS(CORDIC_STEPS), .SIDE_W(8)) u_vec_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (u7_vld),
        .i_x     ($signed(VW'(u7_w))),
        .i_y     (u7_zc),
        .i_side  (u7_md[7:0]),
        .o_vld   (u8b_vld),
        .o_ang   (u8b_ang),
        .o_side  (u8b_md_lo)
    );

    // ------------------------------------------------------------------
    // scale to minutes and degrees, register the result beat
    // ------------------------------------------------------------------
    logic signed [63:0] n_fe, n_fd;
    logic signed [31:0] n_eq, n_dq;
    logic               r_done;
    logic [16:0]        r_md;
    logic signed [16:0] r_eot;
    logic signed [15:0] r_dec;

    assign n_fe = $signed(u8a_ang) * seot_pkg::EOT_SCALE + 64'sh8000_0000;
    assign n_fd = $signed(u8b_ang) * seot_pkg::DEC_SCALE + 64'sh8000_0000;
    assign n_eq = n_fe[63:32];
    assign n_dq = n_fd[63:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= u8a_vld && u8b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_md  <= {u8a_md_hi, u8b_md_lo};
        r_eot <= 17'(-n_eq);
        if (n_dq > seot_pkg::DEC_LIMIT) begin
            r_dec <= seot_pkg::DEC_LIMIT[15:0];
        end else if (n_dq < -seot_pkg::DEC_LIMIT) begin
            r_dec <= 16'(-seot_pkg::DEC_LIMIT);
        end else begin
            r_dec <= n_dq[15:0];
        end
    end

    assign o_done        = r_done;
    assign o_mean_date   = r_md;
    assign o_time_offset = r_eot;
    assign o_declination = r_dec;

endmodule
